// ----- src/mmc3_pkg.sv -----
// Shared types and constants for the MMC3-style bank mapper.
// Holds op codes, register slot codes, bank select codes and address widths.
// No dependencies.
package mmc3_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] op_t;
    typedef logic [2:0] reg_slot_t;

    localparam int PRG_ADDR_BITS = 19;
    localparam int CHR_ADDR_BITS = 18;
    localparam int MAP_BITS      = 19;

    localparam op_t OP_REG_WRITE = 3'd0;
    localparam op_t OP_REG_READ  = 3'd1;
    localparam op_t OP_TICK      = 3'd2;
    localparam op_t OP_CPU_MAP   = 3'd3;
    localparam op_t OP_PPU_MAP   = 3'd4;

    // register slot = {addr[14:13], addr[0]}
    localparam reg_slot_t REG_BANK_SELECT = 3'd0;
    localparam reg_slot_t REG_BANK_DATA   = 3'd1;
    localparam reg_slot_t REG_MIRROR      = 3'd2;
    localparam reg_slot_t REG_UNUSED      = 3'd3;
    localparam reg_slot_t REG_IRQ_LATCH   = 3'd4;
    localparam reg_slot_t REG_IRQ_RELOAD  = 3'd5;
    localparam reg_slot_t REG_IRQ_DISABLE = 3'd6;
    localparam reg_slot_t REG_IRQ_ENABLE  = 3'd7;

    // bank select target codes
    localparam logic [2:0] BSEL_CHR_2K_0 = 3'd0;
    localparam logic [2:0] BSEL_CHR_2K_1 = 3'd1;
    localparam logic [2:0] BSEL_CHR_1K_4 = 3'd2;
    localparam logic [2:0] BSEL_CHR_1K_5 = 3'd3;
    localparam logic [2:0] BSEL_CHR_1K_6 = 3'd4;
    localparam logic [2:0] BSEL_CHR_1K_7 = 3'd5;
    localparam logic [2:0] BSEL_PRG_0    = 3'd6;
    localparam logic [2:0] BSEL_PRG_1    = 3'd7;

    localparam logic [1:0] CFG_PRG_BANK_COUNT  = 2'd0;
    localparam logic [1:0] CFG_CHR_ROM_PRESENT = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCREEN     = 2'd2;

    localparam logic [5:0] PRG_BANK_COUNT_RESET = 6'd32;

    localparam logic [21:0] PRG_MASK = 22'((64'd1 << PRG_ADDR_BITS) - 64'd1);
    localparam logic [18:0] CHR_MASK = 19'((64'd1 << CHR_ADDR_BITS) - 64'd1);

    localparam logic signed [9:0] LINE_PRE_RENDER = -10'sd1;
    localparam logic signed [9:0] LINE_VISIBLE_END = 10'sd240;

endpackage

// ----- src/mmc3_bank_mapper_scanline_irq.sv -----
// MMC3-style bank mapper with scanline IRQ counter: top level.
// Uses mmc3_pkg for op codes, register codes and address widths.
//
// Usage:
//   Request channel (in_valid/in_stall): op, addr, data, scanline and
//   rendering_enabled. A request is taken when in_valid is high and
//   in_stall is low. Each request gives exactly one result on the result
//   channel (out_valid/out_stall): read_data, mapped_address, irq_fire and
//   mirror_horizontal, taken when out_valid is high and out_stall is low.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 bank count, 1 CHR ROM present, 2 four-screen. Write it only
//   while no request is in flight.
//   A request passes through one input register, then the mapping/register/IRQ
//   logic feeding the result register. One request per cycle is sustained
//   while the receiver does not stall; all state is updated as a request moves
//   into the result register, so back-to-back requests see each other's effects.
//   When the receiver stalls, the result holds and the input register holds
//   its request, raising in_stall until the result is taken.
//   Reset clears the register file, banks, IRQ state and mirroring, and sets
//   the configuration to 32 banks, CHR ROM, no four-screen.
module mmc3_bank_mapper_scanline_irq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mmc3_pkg::op_t       op,
    input  logic [15:0]         addr,
    input  mmc3_pkg::byte_t     data,
    input  logic signed [9:0]   scanline,
    input  logic                rendering_enabled,
    output logic                out_valid,
    input  logic                out_stall,
    output mmc3_pkg::byte_t     read_data,
    output logic [18:0]         mapped_address,
    output logic                irq_fire,
    output logic                mirror_horizontal,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import mmc3_pkg::*;

    // input stage
    logic              s1_valid_reg, s1_valid_next;
    op_t               s1_op_reg;
    logic [15:0]       s1_addr_reg;
    byte_t             s1_data_reg;
    logic signed [9:0] s1_line_reg;
    logic              s1_render_reg;

    // result stage
    logic              out_valid_reg, out_valid_next;
    byte_t             read_data_reg, read_data_next;
    logic [18:0]       mapped_reg, mapped_next;
    logic              irq_fire_reg, irq_fire_next;
    logic              mirror_out_reg;

    // mapper state
    byte_t             regfile_reg [8];
    byte_t             regfile_next [8];
    byte_t             chr_bank_reg [8];
    byte_t             chr_bank_next [8];
    byte_t             prg_bank_reg [2];
    byte_t             prg_bank_next [2];
    byte_t             irq_count_reg, irq_count_next;
    byte_t             irq_latch_reg, irq_latch_next;
    logic              irq_enabled_reg, irq_enabled_next;
    logic              reload_pending_reg, reload_pending_next;
    logic              mirror_reg, mirror_next;

    // configuration
    logic [5:0]        prg_bank_count_reg;
    logic              chr_rom_present_reg;
    logic              four_screen_reg;

    logic              in_accept;
    logic              out_load;

    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign mapped_address    = mapped_reg;
    assign irq_fire          = irq_fire_reg;
    assign mirror_horizontal = mirror_out_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // request processing: register file, IRQ counter and address mapping
    always_comb
    begin
        reg_slot_t  slot_code;
        logic       high_addr;
        byte_t      count_a;
        byte_t      count_d;
        logic       in_lines;
        logic       zero;
        logic [7:0] last_half;
        logic [8:0] last_bank;
        logic [8:0] prg_bank;
        logic [1:0] cpu_slot;
        logic [21:0] prg_full;
        logic [2:0] ppu_slot;
        logic [2:0] chr_sel;
        logic [18:0] chr_full;

        for (int i = 0; i < 8; i++)
        begin
            regfile_next[i]  = regfile_reg[i];
            chr_bank_next[i] = chr_bank_reg[i];
        end
        prg_bank_next[0]    = prg_bank_reg[0];
        prg_bank_next[1]    = prg_bank_reg[1];
        irq_count_next      = irq_count_reg;
        irq_latch_next      = irq_latch_reg;
        irq_enabled_next    = irq_enabled_reg;
        reload_pending_next = reload_pending_reg;
        mirror_next         = mirror_reg;
        read_data_next      = '0;
        mapped_next         = '0;
        irq_fire_next       = 1'b0;

        slot_code = {s1_addr_reg[14:13], s1_addr_reg[0]};
        high_addr = s1_addr_reg[15];

        in_lines = (s1_line_reg >= LINE_PRE_RENDER) && (s1_line_reg < LINE_VISIBLE_END);
        count_a  = reload_pending_reg ? irq_latch_reg : irq_count_reg;
        count_d  = (count_a != 8'd0) ? count_a - 8'd1 : 8'd0;
        zero     = 1'b0;

        last_half = 8'({2'b00, prg_bank_count_reg} - 8'd1);
        last_bank = {last_half, 1'b0};
        cpu_slot  = s1_addr_reg[14:13];
        priority if (cpu_slot == 2'd3)
        begin
            prg_bank = last_bank | 9'd1;
        end
        else if (cpu_slot == 2'd1)
        begin
            prg_bank = {1'b0, prg_bank_reg[1]};
        end
        else if ((cpu_slot == 2'd0) == regfile_reg[0][6])
        begin
            prg_bank = last_bank;
        end
        else
        begin
            prg_bank = {1'b0, prg_bank_reg[0]};
        end
        prg_full = {prg_bank, s1_addr_reg[12:0]} & PRG_MASK;

        ppu_slot = s1_addr_reg[12:10];
        chr_sel  = regfile_reg[0][7] ? (ppu_slot ^ 3'd4) : ppu_slot;
        chr_full = {1'b0, chr_bank_reg[chr_sel], s1_addr_reg[9:0]};
        if (!chr_rom_present_reg)
        begin
            chr_full = chr_full + {6'd0, ppu_slot, 10'd0};
        end
        chr_full = chr_full & CHR_MASK;

        unique case (s1_op_reg)
            OP_REG_WRITE:
            begin
                if (high_addr)
                begin
                    regfile_next[slot_code] = s1_data_reg;
                    unique case (slot_code)
                        REG_BANK_DATA:
                        begin
                            unique case (regfile_reg[0][2:0])
                                BSEL_CHR_2K_0:
                                begin
                                    chr_bank_next[0] = {s1_data_reg[7:1], 1'b0};
                                    chr_bank_next[1] = {s1_data_reg[7:1], 1'b1};
                                end
                                BSEL_CHR_2K_1:
                                begin
                                    chr_bank_next[2] = {s1_data_reg[7:1], 1'b0};
                                    chr_bank_next[3] = {s1_data_reg[7:1], 1'b1};
                                end
                                BSEL_CHR_1K_4: chr_bank_next[4] = s1_data_reg;
                                BSEL_CHR_1K_5: chr_bank_next[5] = s1_data_reg;
                                BSEL_CHR_1K_6: chr_bank_next[6] = s1_data_reg;
                                BSEL_CHR_1K_7: chr_bank_next[7] = s1_data_reg;
                                BSEL_PRG_0:    prg_bank_next[0] = s1_data_reg;
                                BSEL_PRG_1:    prg_bank_next[1] = s1_data_reg;
                                default:       prg_bank_next[1] = s1_data_reg;
                            endcase
                        end
                        REG_MIRROR:
                        begin
                            if (!four_screen_reg)
                            begin
                                mirror_next = s1_data_reg[0];
                            end
                        end
                        REG_IRQ_LATCH:   irq_latch_next = s1_data_reg;
                        REG_IRQ_RELOAD:  reload_pending_next = 1'b1;
                        REG_IRQ_DISABLE: irq_enabled_next = 1'b0;
                        REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
                        default:         ;
                    endcase
                end
            end
            OP_REG_READ:
            begin
                if (high_addr)
                begin
                    read_data_next = regfile_reg[slot_code];
                end
            end
            OP_TICK:
            begin
                if (in_lines)
                begin
                    reload_pending_next = 1'b0;
                    irq_count_next      = count_a;
                    if ((s1_line_reg == LINE_PRE_RENDER) || s1_render_reg)
                    begin
                        irq_count_next = count_d;
                        if (count_d == 8'd0)
                        begin
                            irq_count_next = irq_latch_reg;
                            zero           = 1'b1;
                        end
                    end
                end
                irq_fire_next = irq_enabled_reg && zero;
            end
            OP_CPU_MAP:
            begin
                if (high_addr)
                begin
                    mapped_next = prg_full[18:0];
                end
            end
            OP_PPU_MAP:
            begin
                if (s1_addr_reg[15:13] == 3'd0)
                begin
                    mapped_next = chr_full;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                regfile_reg[i]  <= '0;
                chr_bank_reg[i] <= '0;
            end
            prg_bank_reg[0]     <= '0;
            prg_bank_reg[1]     <= '0;
            irq_count_reg       <= '0;
            irq_latch_reg       <= '0;
            irq_enabled_reg     <= 1'b0;
            reload_pending_reg  <= 1'b0;
            mirror_reg          <= 1'b0;
            prg_bank_count_reg  <= PRG_BANK_COUNT_RESET;
            chr_rom_present_reg <= 1'b1;
            four_screen_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    regfile_reg[i]  <= regfile_next[i];
                    chr_bank_reg[i] <= chr_bank_next[i];
                end
                prg_bank_reg[0]    <= prg_bank_next[0];
                prg_bank_reg[1]    <= prg_bank_next[1];
                irq_count_reg      <= irq_count_next;
                irq_latch_reg      <= irq_latch_next;
                irq_enabled_reg    <= irq_enabled_next;
                reload_pending_reg <= reload_pending_next;
                mirror_reg         <= mirror_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PRG_BANK_COUNT:  prg_bank_count_reg  <= cfg_data[5:0];
                    CFG_CHR_ROM_PRESENT: chr_rom_present_reg <= cfg_data[0];
                    CFG_FOUR_SCREEN:     four_screen_reg     <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= op;
            s1_addr_reg   <= addr;
            s1_data_reg   <= data;
            s1_line_reg   <= scanline;
            s1_render_reg <= rendering_enabled;
        end
        if (out_load)
        begin
            read_data_reg  <= read_data_next;
            mapped_reg     <= mapped_next;
            irq_fire_reg   <= irq_fire_next;
            mirror_out_reg <= mirror_next;
        end
    end

endmodule
